/* design/sdi_pkg.sv */
// Shared types, constants and fixed-point helpers for the spring-damper impulse block.
package sdi_pkg;

   localparam int unsigned FRAC_BITS_DEF = 16;
   localparam int unsigned SQRT_STAGES = 32;

   localparam logic [1:0] CSR_STIFFNESS = 2'd0;
   localparam logic [1:0] CSR_DAMPING   = 2'd1;
   localparam logic [1:0] CSR_TIME_STEP = 2'd2;

   localparam logic [30:0] STIFFNESS_RST = 31'd6553600;
   localparam logic [30:0] DAMPING_RST   = 31'd65536;
   localparam logic [30:0] TIME_STEP_RST = 31'd1092;

   typedef struct packed {
      logic [2:0][31:0] sep;
      logic [2:0][31:0] relvel;
      logic [30:0]      rest;
   } item_type;

   typedef struct packed {
      logic [31:0]      distance;
      logic [2:0][32:0] u;
      logic [2:0][31:0] relvel;
      logic [30:0]      rest;
   } axis_type;

   typedef struct packed {
      logic [30:0] stiffness;
      logic [30:0] damping;
      logic [30:0] time_step;
   } cfg_type;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] res;
      if (v > 35'sd2147483647) res = 32'sh7FFF_FFFF;
      else if (v < -35'sd2147483648) res = 32'sh8000_0000;
      else res = v[31:0];
      return res;
   endfunction

   // sign * floor(|a*b| >> frac), saturated; operands within 32-bit signed range
   function automatic logic signed [31:0] mulq(input logic signed [32:0] a,
                                              input logic signed [32:0] b,
                                              input int unsigned frac);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [63:0] p;
      logic        neg;
      logic signed [31:0] res;
      neg = a[32] ^ b[32];
      ma  = a[32] ? 32'(-a) : 32'(a);
      mb  = b[32] ? 32'(-b) : 32'(b);
      p   = (64'(ma) * 64'(mb)) >> frac;
      if (neg) begin
         if (p > 64'h8000_0000) res = 32'sh8000_0000;
         else res = 32'(-p);
      end else begin
         if (p > 64'h7FFF_FFFF) res = 32'sh7FFF_FFFF;
         else res = p[31:0];
      end
      return res;
   endfunction

endpackage

/* design/sdi_sqrt_pipe.sv */
// Squares, sum and one-bit-per-stage integer square root of the separation.
module sdi_sqrt_pipe (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  sdi_pkg::item_type in_item,
   output logic              out_vld,
   output logic [31:0]       out_dist,
   output sdi_pkg::item_type out_item
);
   localparam int unsigned NS = sdi_pkg::SQRT_STAGES;

   logic [2:0][63:0]  sq_ff;
   logic              sq_vld_ff;
   sdi_pkg::item_type sq_item_ff;
   logic [63:0]       sum_ff;
   logic              sum_vld_ff;
   sdi_pkg::item_type sum_item_ff;

   logic [63:0]       n_ff    [0:NS-1];
   logic [63:0]       r_ff    [0:NS-1];
   logic              vld_ff  [0:NS-1];
   sdi_pkg::item_type item_ff [0:NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff  <= 1'b0;
         sum_vld_ff <= 1'b0;
      end else if (adv) begin
         sq_vld_ff  <= in_vld;
         sum_vld_ff <= sq_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [31:0] m;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            m = in_item.sep[i][31] ? 32'(-in_item.sep[i]) : in_item.sep[i];
            sq_ff[i] <= 64'(m) * 64'(m);
         end
         sq_item_ff  <= in_item;
         sum_ff      <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         sum_item_ff <= sq_item_ff;
      end
   end

   for (genvar j = 0; j < NS; j++) begin : g_stage
      localparam logic [63:0] BITV = 64'd1 << (62 - 2 * j);
      logic [63:0]       n_src;
      logic [63:0]       r_src;
      logic              v_src;
      sdi_pkg::item_type it_src;
      logic [63:0]       trial;
      if (j == 0) begin : g_first
         assign n_src  = sum_ff;
         assign r_src  = 64'd0;
         assign v_src  = sum_vld_ff;
         assign it_src = sum_item_ff;
      end else begin : g_next
         assign n_src  = n_ff[j-1];
         assign r_src  = r_ff[j-1];
         assign v_src  = vld_ff[j-1];
         assign it_src = item_ff[j-1];
      end
      assign trial = r_src + BITV;

      always_ff @(posedge clock) begin
         if (reset) vld_ff[j] <= 1'b0;
         else if (adv) vld_ff[j] <= v_src;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (n_src >= trial) begin
               n_ff[j] <= n_src - trial;
               r_ff[j] <= (r_src >> 1) + BITV;
            end else begin
               n_ff[j] <= n_src;
               r_ff[j] <= r_src >> 1;
            end
            item_ff[j] <= it_src;
         end
      end
   end

   assign out_vld  = vld_ff[NS-1];
   assign out_dist = r_ff[NS-1][31:0];
   assign out_item = item_ff[NS-1];
endmodule

/* design/sdi_div_pipe.sv */
// Restoring divider, one quotient bit per stage, three lanes: unit axis = sep / dist.
module sdi_div_pipe #(
   parameter int unsigned FRAC_BITS = sdi_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  logic [31:0]       in_dist,
   input  sdi_pkg::item_type in_item,
   output logic              out_vld,
   output sdi_pkg::axis_type out_axis
);
   localparam int unsigned NS = FRAC_BITS + 1;
   localparam int unsigned DW = 33 + FRAC_BITS;

   logic [2:0][DW-1:0]        rem_ff  [0:NS-1];
   logic [2:0][FRAC_BITS:0]   q_ff    [0:NS-1];
   logic                      vld_ff  [0:NS-1];
   logic [31:0]               dist_ff [0:NS-1];
   sdi_pkg::item_type         item_ff [0:NS-1];

   logic [2:0][DW-1:0] rem_init;

   always_comb begin
      logic [31:0] m;
      for (int i = 0; i < 3; i++) begin
         m = in_item.sep[i][31] ? 32'(-in_item.sep[i]) : in_item.sep[i];
         rem_init[i] = DW'(m) << FRAC_BITS;
      end
   end

   for (genvar j = 0; j < NS; j++) begin : g_stage
      localparam int unsigned K = FRAC_BITS - j;
      logic [2:0][DW-1:0]      rem_src;
      logic [2:0][FRAC_BITS:0] q_src;
      logic                    v_src;
      logic [31:0]             d_src;
      sdi_pkg::item_type       it_src;
      logic [DW-1:0]           dsh;
      if (j == 0) begin : g_first
         assign rem_src = rem_init;
         assign q_src   = '0;
         assign v_src   = in_vld;
         assign d_src   = in_dist;
         assign it_src  = in_item;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign q_src   = q_ff[j-1];
         assign v_src   = vld_ff[j-1];
         assign d_src   = dist_ff[j-1];
         assign it_src  = item_ff[j-1];
      end
      assign dsh = DW'(d_src) << K;

      always_ff @(posedge clock) begin
         if (reset) vld_ff[j] <= 1'b0;
         else if (adv) vld_ff[j] <= v_src;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               if (rem_src[i] >= dsh) begin
                  rem_ff[j][i] <= rem_src[i] - dsh;
                  q_ff[j][i]   <= {q_src[i][FRAC_BITS-1:0], 1'b1};
               end else begin
                  rem_ff[j][i] <= rem_src[i];
                  q_ff[j][i]   <= {q_src[i][FRAC_BITS-1:0], 1'b0};
               end
            end
            dist_ff[j] <= d_src;
            item_ff[j] <= it_src;
         end
      end
   end

   always_comb begin
      logic [32:0] q;
      out_axis.distance = dist_ff[NS-1];
      out_axis.relvel   = item_ff[NS-1].relvel;
      out_axis.rest     = item_ff[NS-1].rest;
      for (int i = 0; i < 3; i++) begin
         q = 33'(q_ff[NS-1][i]);
         out_axis.u[i] = item_ff[NS-1].sep[i][31] ? -q : q;
      end
   end
   assign out_vld = vld_ff[NS-1];
endmodule

/* design/sdi_force_pipe.sv */
// Spring and damping force, impulse magnitude and per-axis impulse, with output register.
module sdi_force_pipe #(
   parameter int unsigned FRAC_BITS = sdi_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  sdi_pkg::cfg_type  cfg,
   input  logic              in_vld,
   input  sdi_pkg::axis_type in_axis,
   output logic              out_vld,
   output logic [2:0][31:0]  out_a,
   output logic [2:0][31:0]  out_b,
   output logic              out_skip
);
   localparam logic [31:0] DIST_EPS =
      32'(((64'd1 << FRAC_BITS) + 64'd999999) / 64'd1000000);

   logic [6:0] vld_ff;

   logic [2:0][32:0] u1_ff, u2_ff, u3_ff, u4_ff, u5_ff;
   logic [5:1]       skip_ff;
   logic [31:0]      stretch_ff;
   logic [2:0][31:0] pv_ff;
   logic [31:0]      force2_ff, relv_ff, force3_ff, damp_ff, total_ff, imp_ff;
   logic [2:0][31:0] a_ff;
   logic             a_skip_ff;
   logic [2:0][31:0] oa_ff, ob_ff;
   logic             oskip_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[5:0], in_vld};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // E1
         stretch_ff <= sdi_pkg::sat32(35'($signed({3'b0, in_axis.distance}))
                                      - 35'($signed({4'b0, in_axis.rest})));
         for (int i = 0; i < 3; i++)
            pv_ff[i] <= sdi_pkg::mulq(33'($signed(in_axis.relvel[i])),
                                      $signed(in_axis.u[i]), FRAC_BITS);
         u1_ff      <= in_axis.u;
         skip_ff[1] <= in_axis.distance < DIST_EPS;
         // E2
         force2_ff  <= sdi_pkg::mulq($signed({2'b0, cfg.stiffness}),
                                     33'($signed(stretch_ff)), FRAC_BITS);
         relv_ff    <= sdi_pkg::sat32(35'($signed(pv_ff[0])) + 35'($signed(pv_ff[1]))
                                      + 35'($signed(pv_ff[2])));
         u2_ff      <= u1_ff;
         skip_ff[2] <= skip_ff[1];
         // E3
         damp_ff    <= sdi_pkg::mulq($signed({2'b0, cfg.damping}),
                                     33'($signed(relv_ff)), FRAC_BITS);
         force3_ff  <= force2_ff;
         u3_ff      <= u2_ff;
         skip_ff[3] <= skip_ff[2];
         // E4
         total_ff   <= sdi_pkg::sat32(35'($signed(force3_ff)) + 35'($signed(damp_ff)));
         u4_ff      <= u3_ff;
         skip_ff[4] <= skip_ff[3];
         // E5
         imp_ff     <= sdi_pkg::mulq(33'($signed(total_ff)),
                                     $signed({2'b0, cfg.time_step}), FRAC_BITS);
         u5_ff      <= u4_ff;
         skip_ff[5] <= skip_ff[4];
         // E6
         for (int i = 0; i < 3; i++)
            a_ff[i] <= sdi_pkg::mulq(33'($signed(imp_ff)), $signed(u5_ff[i]), FRAC_BITS);
         a_skip_ff  <= skip_ff[5];
         // output register; short distance forces zero impulse
         for (int i = 0; i < 3; i++) begin
            oa_ff[i] <= a_skip_ff ? 32'd0 : a_ff[i];
            ob_ff[i] <= a_skip_ff ? 32'd0 : sdi_pkg::sat32(-35'($signed(a_ff[i])));
         end
         oskip_ff   <= a_skip_ff;
      end
   end

   assign out_vld  = vld_ff[6];
   assign out_a    = oa_ff;
   assign out_b    = ob_ff;
   assign out_skip = oskip_ff;
endmodule

/* design/spring_damper_impulse.sv */
// Top level of the damped spring joint impulse pipeline.
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    sep_x/y/z, relvel_x/y/z, rest_len
// rsp      out        rsp_valid/rsp_ready    impulse_a_x/y/z, impulse_b_x/y/z, skipped
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One transaction per cycle sustained while results are taken (rsp_ready high or no result
// pending); the path runs squares, sum, bit-per-stage square root, divider and force stages.
// Synchronous reset clears all valid bits and loads register defaults.
// A stalled result holds the whole pipeline in place; nothing is dropped or repeated.
module spring_damper_impulse #(
   parameter int unsigned FRAC_BITS = sdi_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_sep_x,
   input  logic [31:0] req_sep_y,
   input  logic [31:0] req_sep_z,
   input  logic [31:0] req_relvel_x,
   input  logic [31:0] req_relvel_y,
   input  logic [31:0] req_relvel_z,
   input  logic [30:0] req_rest_len,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_impulse_a_x,
   output logic [31:0] rsp_impulse_a_y,
   output logic [31:0] rsp_impulse_a_z,
   output logic [31:0] rsp_impulse_b_x,
   output logic [31:0] rsp_impulse_b_y,
   output logic [31:0] rsp_impulse_b_z,
   output logic        rsp_skipped,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data
);
   sdi_pkg::cfg_type  cfg_ff;
   sdi_pkg::item_type item;
   sdi_pkg::item_type sq_item;
   sdi_pkg::axis_type axis;
   logic              adv, sq_vld, dv_vld;
   logic [31:0]       root_dist;
   logic [2:0][31:0]  imp_a, imp_b;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stiffness <= sdi_pkg::STIFFNESS_RST;
         cfg_ff.damping   <= sdi_pkg::DAMPING_RST;
         cfg_ff.time_step <= sdi_pkg::TIME_STEP_RST;
      end else if (csr_valid) begin
         case (csr_index)
            sdi_pkg::CSR_STIFFNESS: cfg_ff.stiffness <= csr_data;
            sdi_pkg::CSR_DAMPING:   cfg_ff.damping   <= csr_data;
            sdi_pkg::CSR_TIME_STEP: cfg_ff.time_step <= csr_data;
            default: ;
         endcase
      end
   end

   assign item.sep    = {req_sep_z, req_sep_y, req_sep_x};
   assign item.relvel = {req_relvel_z, req_relvel_y, req_relvel_x};
   assign item.rest   = req_rest_len;

   sdi_sqrt_pipe u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (req_valid),
      .in_item  (item),
      .out_vld  (sq_vld),
      .out_dist (root_dist),
      .out_item (sq_item)
   );

   sdi_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (sq_vld),
      .in_dist  (root_dist),
      .in_item  (sq_item),
      .out_vld  (dv_vld),
      .out_axis (axis)
   );

   sdi_force_pipe #(.FRAC_BITS(FRAC_BITS)) u_force (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .cfg      (cfg_ff),
      .in_vld   (dv_vld),
      .in_axis  (axis),
      .out_vld  (rsp_valid),
      .out_a    (imp_a),
      .out_b    (imp_b),
      .out_skip (rsp_skipped)
   );

   assign rsp_impulse_a_x = imp_a[0];
   assign rsp_impulse_a_y = imp_a[1];
   assign rsp_impulse_a_z = imp_a[2];
   assign rsp_impulse_b_x = imp_b[0];
   assign rsp_impulse_b_y = imp_b[1];
   assign rsp_impulse_b_z = imp_b[2];

   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_skipped |-> rsp_impulse_a_x == 32'd0 && rsp_impulse_a_y == 32'd0
         && rsp_impulse_a_z == 32'd0 && rsp_impulse_b_x == 32'd0
         && rsp_impulse_b_y == 32'd0 && rsp_impulse_b_z == 32'd0)
      else $error("skipped result carries nonzero impulse");

   a_opposite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_impulse_a_x != 32'h8000_0000 |->
         rsp_impulse_b_x == 32'(-rsp_impulse_a_x))
      else $error("body b impulse is not opposite to body a");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");
endmodule
